// File: rtl/keyed_slot_table_oldest_evict_defines.svh
// Assertion macros shared by the slot table RTL.
`ifndef KEYED_SLOT_TABLE_OLDEST_EVICT_DEFINES_SVH
`define KEYED_SLOT_TABLE_OLDEST_EVICT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define KSTO_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("ksto: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define KSTO_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("ksto: next-cycle check failed");
`else
`define KSTO_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define KSTO_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// File: rtl/ksto_pkg.sv
// Types and constants of the keyed slot table.
`default_nettype none

package ksto_pkg;

    localparam int FIELD_W      = 32;
    localparam int SLOT_INDEX_W = 6;
    localparam int PAYLOAD_W    = 64;

    // Key folding constants
    localparam logic [FIELD_W-1:0] FOLD_LIMIT = 32'd9000;
    localparam logic [FIELD_W-1:0] FOLD_SUB   = 32'd8000;
    localparam logic [FIELD_W-1:0] DIV_HI     = 32'd10000;
    localparam logic [FIELD_W-1:0] DIV_LO     = 32'd100;
    localparam logic [FIELD_W-1:0] SCALE_HI   = 32'd1000000;

    // Reciprocals: floor(x * RECIP >> SHIFT) equals x / DIV for every 32-bit x
    localparam logic [FIELD_W-1:0] RECIP_HI       = 32'd3518437209;
    localparam int                 RECIP_HI_SHIFT = 45;
    localparam logic [FIELD_W-1:0] RECIP_LO       = 32'd2748779070;
    localparam int                 RECIP_LO_SHIFT = 38;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_FETCH = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [FIELD_W-1:0]     field_one;
        logic [FIELD_W-1:0]     field_two;
        logic [FIELD_W-1:0]     field_three;
        logic [PAYLOAD_W-1:0]   payload_in;
        logic [FIELD_W-1:0]     now_time;
    } t_in_word;

    typedef struct packed {
        logic                    hit;
        logic                    evicted;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic [PAYLOAD_W-1:0]    payload_out;
    } t_out_word;

    // One slot's bookkeeping entry
    typedef struct packed {
        logic               busy;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] stamp;
    } t_meta;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_SCAN,
        ST_FIN,
        ST_READ,
        ST_RESP
    } t_state;

    typedef enum logic [3:0] {
        KS_IDLE,
        KS_A_MUL,
        KS_A_QMUL,
        KS_A_SUB,
        KS_A_SCALE,
        KS_B_MUL,
        KS_B_QMUL,
        KS_B_SUB,
        KS_B_SCALE,
        KS_C_MUL,
        KS_C_QMUL,
        KS_C_SUB,
        KS_SUM
    } t_key_step;

endpackage

`default_nettype wire

// File: rtl/keyed_slot_table_oldest_evict.sv
// Keyed slot table with oldest-entry eviction: control, scan and result register.
//
// Channel  Direction  Handshake                  Word
// in       input      i_in_valid / o_in_stall    t_in_word
// out      output     o_out_valid / i_out_stall  t_out_word
//
// Sequence per word: the key unit works on its shared multiplier, the scan reads one slot
// per cycle, then write-back and, on a fetch hit, one payload memory read.
// Reset: a clearing pass writes every bookkeeping entry, stall high.
// Stalls: a result waits in the output register while the next word is taken; a finished
// result holds in place until that register frees.
`default_nettype none
`include "keyed_slot_table_oldest_evict_defines.svh"

module keyed_slot_table_oldest_evict
    import ksto_pkg::*;
#(
    parameter int SLOT_COUNT   = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int                 IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // Control state
    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_ptr, n_ptr;
    logic                    r_issue_done, n_issue_done;
    logic                    r_rd_pend, n_rd_pend;
    logic                    r_free_found, n_free_found;
    logic                    r_match_found, n_match_found;
    logic                    r_best_valid, n_best_valid;
    logic                    r_out_valid, n_out_valid;

    // Operation and scan payload
    t_opcode                 r_op, n_op;
    logic [FIELD_W-1:0]      r_now, n_now;
    logic [PAYLOAD_BITS-1:0] r_payload, n_payload;
    logic [IDX_W-1:0]        r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;
    logic [IDX_W-1:0]        r_match_idx, n_match_idx;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [FIELD_W-1:0]      r_best_time, n_best_time;
    t_out_word               r_res, n_res;
    t_out_word               r_out, n_out;

    // Memory and key unit hookup
    logic                    meta_we;
    logic [IDX_W-1:0]        meta_addr;
    t_meta                   meta_wdata;
    t_meta                   meta_rdata;
    logic                    data_we;
    logic [IDX_W-1:0]        data_addr;
    logic [PAYLOAD_BITS-1:0] data_rdata;
    logic                    key_start;
    logic                    key_done;
    logic [FIELD_W-1:0]      key;
    logic [IDX_W-1:0]        fin_idx;
    logic                    in_take;

    ksto_key u_key (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (key_start),
        .i_field_one   (i_in_word.field_one),
        .i_field_two   (i_in_word.field_two),
        .i_field_three (i_in_word.field_three),
        .o_done        (key_done),
        .o_key         (key)
    );

    ksto_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W),
        .DATA_W (PAYLOAD_BITS)
    ) u_mem (
        .i_clk        (i_clk),
        .i_meta_we    (meta_we),
        .i_meta_addr  (meta_addr),
        .i_meta_wdata (meta_wdata),
        .o_meta_rdata (meta_rdata),
        .i_data_we    (data_we),
        .i_data_addr  (data_addr),
        .i_data_wdata (r_payload),
        .o_data_rdata (data_rdata)
    );

    // Slot chosen at the end of the scan
    always_comb begin
        if (r_op == OP_STORE) begin
            if (r_free_found) begin
                fin_idx = r_free_idx;
            end else if (r_best_valid) begin
                fin_idx = r_best_idx;
            end else begin
                fin_idx = '0;
            end
        end else begin
            fin_idx = r_match_idx;
        end
    end

    assign in_take = i_in_valid && (r_state == ST_IDLE);

    // Next state, memory control and result staging
    always_comb begin
        n_state       = r_state;
        n_ptr         = r_ptr;
        n_issue_done  = r_issue_done;
        n_rd_pend     = 1'b0;
        n_free_found  = r_free_found;
        n_match_found = r_match_found;
        n_best_valid  = r_best_valid;
        n_op          = r_op;
        n_now         = r_now;
        n_payload     = r_payload;
        n_rd_idx      = r_rd_idx;
        n_free_idx    = r_free_idx;
        n_match_idx   = r_match_idx;
        n_best_idx    = r_best_idx;
        n_best_time   = r_best_time;
        n_res         = r_res;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        meta_we       = 1'b0;
        meta_addr     = r_ptr;
        meta_wdata    = '0;
        data_we       = 1'b0;
        data_addr     = fin_idx;
        key_start     = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                meta_we = 1'b1;
                n_ptr   = r_ptr + IDX_W'(1);
                if (r_ptr == LAST_IDX) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    key_start     = 1'b1;
                    n_op          = i_in_word.opcode;
                    n_now         = i_in_word.now_time;
                    n_payload     = i_in_word.payload_in[PAYLOAD_BITS-1:0];
                    n_ptr         = '0;
                    n_issue_done  = 1'b0;
                    n_free_found  = 1'b0;
                    n_match_found = 1'b0;
                    n_best_valid  = 1'b0;
                    n_state       = ST_KEY;
                end
            end
            ST_KEY: begin
                if (key_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle
                if (!r_issue_done) begin
                    n_rd_pend = 1'b1;
                    n_rd_idx  = r_ptr;
                    n_ptr     = r_ptr + IDX_W'(1);
                    if (r_ptr == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end
                end
                // Inspect the entry read last cycle
                if (r_rd_pend) begin
                    if (!meta_rdata.busy && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                    if (meta_rdata.busy && (meta_rdata.key == key) && !r_match_found) begin
                        n_match_found = 1'b1;
                        n_match_idx   = r_rd_idx;
                    end
                    // Greatest positive age is the oldest stamp below now
                    if ((meta_rdata.stamp < r_now) &&
                        (!r_best_valid || (meta_rdata.stamp < r_best_time))) begin
                        n_best_valid = 1'b1;
                        n_best_time  = meta_rdata.stamp;
                        n_best_idx   = r_rd_idx;
                    end
                    if (r_rd_idx == LAST_IDX) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                meta_addr = fin_idx;
                if (r_op == OP_STORE) begin
                    meta_we    = 1'b1;
                    meta_wdata = '{busy: 1'b1, key: key, stamp: r_now};
                    data_we    = 1'b1;
                    n_res      = '{hit: 1'b1, evicted: !r_free_found,
                                   slot_index: SLOT_INDEX_W'(fin_idx), payload_out: '0};
                    n_state    = ST_RESP;
                end else if (r_match_found) begin
                    // Release the slot; payload read lands next cycle
                    meta_we = 1'b1;
                    n_state = ST_READ;
                end else begin
                    n_res   = '{hit: 1'b0, evicted: 1'b0, slot_index: '0, payload_out: '0};
                    n_state = ST_RESP;
                end
            end
            ST_READ: begin
                n_res   = '{hit: 1'b1, evicted: 1'b0,
                            slot_index: SLOT_INDEX_W'(r_match_idx),
                            payload_out: PAYLOAD_W'(data_rdata)};
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_ptr         <= '0;
            r_issue_done  <= 1'b0;
            r_rd_pend     <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
            r_best_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ptr         <= n_ptr;
            r_issue_done  <= n_issue_done;
            r_rd_pend     <= n_rd_pend;
            r_free_found  <= n_free_found;
            r_match_found <= n_match_found;
            r_best_valid  <= n_best_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_now       <= n_now;
        r_payload   <= n_payload;
        r_rd_idx    <= n_rd_idx;
        r_free_idx  <= n_free_idx;
        r_match_idx <= n_match_idx;
        r_best_idx  <= n_best_idx;
        r_best_time <= n_best_time;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `KSTO_ASSERT_IMP(a_miss_clean, i_clk, i_rst_n, o_out_valid && !o_out_word.hit, o_out_word.slot_index == 6'd0 && o_out_word.payload_out == 64'd0 && !o_out_word.evicted)
    `KSTO_ASSERT_IMP(a_evict_is_store, i_clk, i_rst_n, o_out_valid && o_out_word.evicted, o_out_word.hit && o_out_word.payload_out == 64'd0)
    `KSTO_ASSERT_IMP(a_write_phase, i_clk, i_rst_n, meta_we, r_state == ST_CLEAR || r_state == ST_FIN)
    `KSTO_ASSERT_NXT(a_scan_fresh, i_clk, i_rst_n, in_take, r_state == ST_KEY && !r_free_found && !r_match_found && !r_best_valid)

endmodule

`default_nettype wire

// File: rtl/ksto_key.sv
// Key builder: folds three fields into a 32-bit key on one shared multiplier.
`default_nettype none
`include "keyed_slot_table_oldest_evict_defines.svh"

module ksto_key
    import ksto_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [FIELD_W-1:0] i_field_one,
    input  logic [FIELD_W-1:0] i_field_two,
    input  logic [FIELD_W-1:0] i_field_three,
    output logic               o_done,
    output logic [FIELD_W-1:0] o_key
);

    t_key_step              r_step, n_step;
    logic                   r_done, n_done;
    logic [FIELD_W-1:0]     r_a, n_a;
    logic [FIELD_W-1:0]     r_b, n_b;
    logic [FIELD_W-1:0]     r_c, n_c;
    logic [FIELD_W-1:0]     r_acc, n_acc;
    logic [2*FIELD_W-1:0]   r_prod, n_prod;
    logic [FIELD_W-1:0]     mul_x, mul_y;

    // Sequencer: each remainder is x - (x * recip >> shift) * div; the first two are then scaled
    always_comb begin
        n_step = r_step;
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_acc  = r_acc;
        mul_x  = '0;
        mul_y  = '0;
        n_done = 1'b0;
        unique case (r_step)
            KS_IDLE: begin
                if (i_start) begin
                    n_a    = (i_field_one > FOLD_LIMIT) ? i_field_one - FOLD_SUB
                                                        : i_field_one;
                    n_b    = i_field_two;
                    n_c    = i_field_three;
                    n_acc  = '0;
                    n_step = KS_A_MUL;
                end
            end
            KS_A_MUL: begin
                mul_x  = r_a;
                mul_y  = RECIP_HI;
                n_step = KS_A_QMUL;
            end
            KS_A_QMUL: begin
                mul_x  = FIELD_W'(r_prod[2*FIELD_W-1:RECIP_HI_SHIFT]);
                mul_y  = DIV_HI;
                n_step = KS_A_SUB;
            end
            KS_A_SUB: begin
                n_a    = r_a - r_prod[FIELD_W-1:0];
                n_step = KS_A_SCALE;
            end
            KS_A_SCALE: begin
                mul_x  = r_a;
                mul_y  = SCALE_HI;
                n_step = KS_B_MUL;
            end
            KS_B_MUL: begin
                n_acc  = r_prod[FIELD_W-1:0];
                mul_x  = r_b;
                mul_y  = RECIP_HI;
                n_step = KS_B_QMUL;
            end
            KS_B_QMUL: begin
                mul_x  = FIELD_W'(r_prod[2*FIELD_W-1:RECIP_HI_SHIFT]);
                mul_y  = DIV_HI;
                n_step = KS_B_SUB;
            end
            KS_B_SUB: begin
                n_b    = r_b - r_prod[FIELD_W-1:0];
                n_step = KS_B_SCALE;
            end
            KS_B_SCALE: begin
                mul_x  = r_b;
                mul_y  = DIV_LO;
                n_step = KS_C_MUL;
            end
            KS_C_MUL: begin
                n_acc  = r_acc + r_prod[FIELD_W-1:0];
                mul_x  = r_c;
                mul_y  = RECIP_LO;
                n_step = KS_C_QMUL;
            end
            KS_C_QMUL: begin
                mul_x  = FIELD_W'(r_prod[2*FIELD_W-1:RECIP_LO_SHIFT]);
                mul_y  = DIV_LO;
                n_step = KS_C_SUB;
            end
            KS_C_SUB: begin
                n_c    = r_c - r_prod[FIELD_W-1:0];
                n_step = KS_SUM;
            end
            KS_SUM: begin
                n_acc  = r_acc + r_c;
                n_done = 1'b1;
                n_step = KS_IDLE;
            end
            default: begin
                n_step = KS_IDLE;
            end
        endcase
        n_prod = (2*FIELD_W)'(mul_x) * (2*FIELD_W)'(mul_y);
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= KS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_acc  <= n_acc;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_key  = r_acc;

    `KSTO_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, r_step == KS_IDLE)
    `KSTO_ASSERT_NXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `KSTO_ASSERT_IMP(a_done_back_idle, i_clk, i_rst_n, r_done, r_step == KS_IDLE)

endmodule

`default_nettype wire

// File: rtl/ksto_mem.sv
// Slot table storage: bookkeeping memory and payload memory, registered reads.
`default_nettype none

module ksto_mem
    import ksto_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_meta_we,
    input  logic [ADDR_W-1:0] i_meta_addr,
    input  t_meta             i_meta_wdata,
    output t_meta             o_meta_rdata,
    input  logic              i_data_we,
    input  logic [ADDR_W-1:0] i_data_addr,
    input  logic [DATA_W-1:0] i_data_wdata,
    output logic [DATA_W-1:0] o_data_rdata
);

    t_meta             r_meta_mem [DEPTH];
    logic [DATA_W-1:0] r_data_mem [DEPTH];
    t_meta             r_meta_rd;
    logic [DATA_W-1:0] r_data_rd;

    // Key, busy flag and timestamp
    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            r_meta_mem[i_meta_addr] <= i_meta_wdata;
        end
        r_meta_rd <= r_meta_mem[i_meta_addr];
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_data_we) begin
            r_data_mem[i_data_addr] <= i_data_wdata;
        end
        r_data_rd <= r_data_mem[i_data_addr];
    end

    assign o_meta_rdata = r_meta_rd;
    assign o_data_rdata = r_data_rd;

endmodule

`default_nettype wire

// File: sim/keyed_slot_table_oldest_evict_tb.sv
// Self-checking testbench for the keyed slot table: store, fetch, oldest-entry eviction.
module keyed_slot_table_oldest_evict_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ksto_pkg::*;

    localparam int SLOTS = 64;

    typedef struct {
        logic [31:0] f1;
        logic [31:0] f2;
        logic [31:0] f3;
    } t_key_fields;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    keyed_slot_table_oldest_evict DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the slot table
    logic [31:0] shadow_key [SLOTS];
    bit          shadow_busy [SLOTS];
    logic [31:0] shadow_stamp [SLOTS];
    logic [63:0] shadow_data [SLOTS];

    t_in_word    pending_words [$];
    t_out_word   expected_results [$];
    t_key_fields stored_keys [$];
    logic [31:0] clock_now = 32'd10;

    int total_words = 0;
    int accepted_words = 0;
    int checked_results = 0;
    int error_count = 0;
    int n_stores = 0;
    int n_evictions = 0;
    int n_no_positive_age = 0;
    int n_fetch_hits = 0;
    int n_fetch_misses = 0;
    bit hold_output = 1'b0;

    // Key folding: high bank numbers drop 8000, then three decimal fields pack
    function automatic logic [31:0] fold_key(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        logic [31:0] k;
        if (a > 32'd9000)
            a = a - 32'd8000;
        k = (a % 32'd10000) * 32'd1000000;
        k = k + (b % 32'd10000) * 32'd100;
        k = k + (c % 32'd100);
        return k;
    endfunction

    // Apply one word to the shadow table and return the result it produces
    function automatic t_out_word slot_table_access(t_in_word w);
        t_out_word   r;
        logic [31:0] key;
        longint      best;
        longint      age;
        int          sel;
        int          i;
        bit          found;
        r = '0;
        sel = 0;
        found = 1'b0;
        key = fold_key(w.field_one, w.field_two, w.field_three);
        if (w.opcode == OP_STORE) begin
            for (i = 0; i < SLOTS && !found; i++) begin
                if (!shadow_busy[i]) begin
                    sel = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // Oldest entry by signed age, lowest slot on ties
                best = 0;
                for (i = 0; i < SLOTS; i++) begin
                    age = longint'({32'h0, w.now_time}) - longint'({32'h0, shadow_stamp[i]});
                    if (age > best) begin
                        best = age;
                        sel = i;
                    end
                end
                r.evicted = 1'b1;
                n_evictions++;
                if (best == 0)
                    n_no_positive_age++;
            end
            shadow_key[sel] = key;
            shadow_busy[sel] = 1'b1;
            shadow_stamp[sel] = w.now_time;
            shadow_data[sel] = w.payload_in;
            r.hit = 1'b1;
            r.slot_index = sel[SLOT_INDEX_W-1:0];
            n_stores++;
        end else begin
            for (i = 0; i < SLOTS && !found; i++) begin
                if (shadow_busy[i] && shadow_key[i] == key) begin
                    sel = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                r.slot_index = sel[SLOT_INDEX_W-1:0];
                r.payload_out = shadow_data[sel];
                shadow_key[sel] = '0;
                shadow_busy[sel] = 1'b0;
                shadow_stamp[sel] = '0;
                n_fetch_hits++;
            end else begin
                n_fetch_misses++;
            end
        end
        return r;
    endfunction

    task automatic add_word(t_opcode op, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [63:0] data, logic [31:0] stamp);
        t_in_word w;
        w.opcode = op;
        w.field_one = a;
        w.field_two = b;
        w.field_three = c;
        w.payload_in = data;
        w.now_time = stamp;
        pending_words.push_back(w);
    endtask

    // Field values: small, tiny, full range and fold boundaries
    function automatic logic [31:0] random_field();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom_range(0, 20000);
            2: v = $urandom;
            3: begin
                case ($urandom_range(0, 5))
                    0: v = 32'd0;
                    1: v = 32'd9000;
                    2: v = 32'd9001;
                    3: v = 32'd17999;
                    4: v = 32'd18000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom_range(0, 99);
        endcase
        return v;
    endfunction

    // One random word; fetches mostly aim at keys stored earlier
    function automatic t_in_word random_word(int store_pct);
        t_in_word    w;
        t_key_fields t;
        int          pick;
        w.payload_in = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            w.now_time = '0;
        end else if (pick < 5) begin
            w.now_time = $urandom;
        end else begin
            clock_now = clock_now + $urandom_range(0, 40);
            w.now_time = clock_now;
        end
        if ($urandom_range(0, 99) < store_pct) begin
            w.opcode = OP_STORE;
            t.f1 = random_field();
            t.f2 = random_field();
            t.f3 = ($urandom_range(0, 3) == 0) ? random_field() : 32'd0;
            stored_keys.push_back(t);
            if (stored_keys.size() > 160)
                void'(stored_keys.pop_front());
        end else begin
            w.opcode = OP_FETCH;
            if (stored_keys.size() > 0 && $urandom_range(0, 9) < 8) begin
                t = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                // Aliases meant to fold to the same key
                if ($urandom_range(0, 3) == 0)
                    t.f2 = t.f2 + 32'd10000 * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    t.f3 = t.f3 + 32'd100 * $urandom_range(1, 3);
                if (t.f1 > 32'd1000 && t.f1 < 32'd10000 && $urandom_range(0, 1) == 0)
                    t.f1 = t.f1 + 32'd8000;
            end else begin
                t.f1 = random_field();
                t.f2 = random_field();
                t.f3 = random_field();
            end
        end
        w.field_one = t.f1;
        w.field_two = t.f2;
        w.field_three = t.f3;
        return w;
    endfunction

    // Reset and shadow initialization
    initial begin : reset_seq
        int i;
        for (i = 0; i < SLOTS; i++) begin
            shadow_key[i] = '0;
            shadow_busy[i] = 1'b0;
            shadow_stamp[i] = '0;
            shadow_data[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: present the next pending word once the current one is taken
    always @(posedge i_clk) begin
        bit took;
        int idle_pct;
        took = in_valid && !in_stall;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (took) begin
                expected_results.push_back(slot_table_access(in_word));
                accepted_words++;
            end
            if (accepted_words < total_words / 3)
                idle_pct = 6;
            else if (accepted_words < 2 * total_words / 3)
                idle_pct = 74;
            else
                idle_pct = 0;
            if (!in_valid || took) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        int        idle_pct;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                checked_results++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d arrived with nothing expected: %p",
                                 checked_results, out_word);
                end else begin
                    want = expected_results.pop_front();
                    if (out_word.hit !== want.hit || out_word.evicted !== want.evicted
                        || out_word.slot_index !== want.slot_index
                        || out_word.payload_out !== want.payload_out) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("result %0d mismatch: expected hit=%b ev=%b slot=%0d data=%h",
                                     checked_results, want.hit, want.evicted,
                                     want.slot_index, want.payload_out);
                            $display("result %0d mismatch: got hit=%b ev=%b slot=%0d data=%h",
                                     checked_results, out_word.hit, out_word.evicted,
                                     out_word.slot_index, out_word.payload_out);
                        end
                    end
                end
            end
            if (accepted_words < total_words / 3)
                idle_pct = 74;
            else if (accepted_words < 2 * total_words / 3)
                idle_pct = 6;
            else
                idle_pct = 0;
            out_stall <= hold_output || ($urandom_range(0, 99) < idle_pct);
        end
    end

    // Long receiver hold-off so the table backs up into the input
    initial begin : long_hold
        int n;
        while (accepted_words < 400) @(posedge i_clk);
        hold_output <= 1'b1;
        for (n = 0; n < 500; n++) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    // Stimulus and end of run
    initial begin : run_control
        int e;
        int j;
        int store_pct;
        // Key zero on an empty table, then stored and released
        add_word(OP_FETCH, 32'd0, 32'd0, 32'd0, 64'd0, 32'd5);
        add_word(OP_STORE, 32'd0, 32'd0, 32'd0, 64'h0123_4567_89AB_CDEF, 32'd10);
        add_word(OP_FETCH, 32'd0, 32'd0, 32'd0, 64'd0, 32'd11);
        add_word(OP_FETCH, 32'd0, 32'd0, 32'd0, 64'd0, 32'd12);
        // Fold boundaries and field extremes
        add_word(OP_STORE, 32'd9001, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd20);
        add_word(OP_STORE, 32'd9000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 32'hFFFF_FFFF);
        add_word(OP_STORE, 32'd17999, 32'd10000, 32'd100, 64'h5555_5555_5555_5555, 32'd30);
        add_word(OP_STORE, 32'd18000, 32'd5, 32'd7, 64'hAAAA_AAAA_AAAA_AAAA, 32'd40);
        add_word(OP_STORE, 32'd0, 32'd5, 32'd7, 64'h1111_2222_3333_4444, 32'd41);
        add_word(OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 64'h8000_0000_0000_0001,
                 32'h8000_0000);
        add_word(OP_FETCH, 32'd1001, 32'd0, 32'd0, 64'd0, 32'd50);
        add_word(OP_FETCH, 32'd9000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 32'd51);
        add_word(OP_FETCH, 32'd9999, 32'd0, 32'd0, 64'd0, 32'd52);
        // Duplicate keys: the first busy slot wins; the next fetch folds to a different key
        add_word(OP_FETCH, 32'd0, 32'd5, 32'd7, 64'd0, 32'd53);
        add_word(OP_FETCH, 32'd10000, 32'd10005, 32'd107, 64'd0, 32'd54);
        add_word(OP_FETCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 64'd0, 32'd55);
        add_word(OP_FETCH, 32'd1234, 32'd5678, 32'd90, 64'd0, 32'd56);
        clock_now = 32'd100;
        // Random episodes draw from fill-heavy, balanced and drain-heavy mixes
        for (e = 0; e < 17; e++) begin
            case ($urandom_range(0, 2))
                0: store_pct = 25;
                1: store_pct = 55;
                default: store_pct = 85;
            endcase
            for (j = 0; j < 96; j++)
                pending_words.push_back(random_word(store_pct));
        end
        total_words = pending_words.size();

        while (pending_words.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        $display("covered %0d words: %0d stores with %0d evictions (%0d with no positive age)",
                 accepted_words, n_stores, n_evictions, n_no_positive_age);
        $display("fetches: %0d hits, %0d misses; %0d results checked, %0d errors",
                 n_fetch_hits, n_fetch_misses, checked_results, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
